>>> rtl/core/hsv2rgb_pkg.sv
// shared types and constants for the hsv to rgb converter
// no dependencies

package hsv2rgb_pkg;

  // hue is split into this many sextants around the color circle
  localparam int unsigned SEXTANTS = 6;

  typedef logic [2:0] sextant_t;

  // sextant codes, named after the hue span they cover
  localparam sextant_t SEXT_RED_YEL = 3'd0;
  localparam sextant_t SEXT_YEL_GRN = 3'd1;
  localparam sextant_t SEXT_GRN_CYN = 3'd2;
  localparam sextant_t SEXT_CYN_BLU = 3'd3;
  localparam sextant_t SEXT_BLU_MAG = 3'd4;
  localparam sextant_t SEXT_MAG_RED = 3'd5;

endpackage

>>> rtl/core/hsv2rgb_if.sv
// valid/ready channel interfaces for the hsv to rgb converter
// no dependencies

interface hsv2rgb_hsv_if #(
  parameter int unsigned FRAC_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS:0]   saturation;
  logic [FRAC_BITS:0]   brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if #(
  parameter int unsigned FRAC_BITS = 16
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] red;
  logic [FRAC_BITS:0] green;
  logic [FRAC_BITS:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/core/hsv_to_rgb_converter.sv
// hsv to rgb converter, four-stage pipeline with per-stage valid bits
// depends on hsv2rgb_pkg and the channel interfaces in hsv2rgb_if.sv

// Converts one hue, saturation and value request to red, green and blue, all
// unsigned fixed point with FRAC_BITS fraction bits (1.0 is 2**FRAC_BITS).
// Hue is a pure fraction and wraps around the circle; saturation and value
// above 1.0 clamp to 1.0. Zero value gives black, zero saturation gives gray.
// Throughput is one request per clock while the output is not stalled. From
// input accept to output valid a request passes one stage for clamping and
// hue*6, one for the three first-level products (p and the two saturation
// scalings), one for the q and t products, and the output register that
// routes by sextant. Each stage has its own valid bit and loads whenever it
// is empty or the stage after it moves, so bubbles close up and a stalled
// output still lets new requests enter until the pipeline is full.

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsv2rgb_hsv_if.sink          hsv_i,
  hsv2rgb_rgb_if.source        rgb_o
);

  // fixed point widths: values span 0..1.0 inclusive, so one extra bit
  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * VW;
  localparam int unsigned HW = FRAC_BITS + 3;
  localparam int unsigned NSTAGES = 4;
  localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage 1: clamped inputs, sextant and fraction
  typedef struct packed {
    sextant_t             sext;
    logic [FRAC_BITS-1:0] frac;
    logic [VW-1:0]        sat;
    logic [VW-1:0]        val;
    logic                 black;
    logic                 gray;
  } s1_t;

  // stage 2: p plus the saturation terms feeding q and t
  typedef struct packed {
    sextant_t      sext;
    logic [VW-1:0] val;
    logic [VW-1:0] p;
    logic [VW-1:0] kq;
    logic [VW-1:0] kt;
    logic          black;
    logic          gray;
  } s2_t;

  // stage 3: all four routing candidates
  typedef struct packed {
    sextant_t      sext;
    logic [VW-1:0] val;
    logic [VW-1:0] p;
    logic [VW-1:0] q;
    logic [VW-1:0] t;
    logic          black;
    logic          gray;
  } s3_t;

  logic [NSTAGES-1:0] vld_q, vld_d;
  logic [NSTAGES-1:0] stage_en;

  s1_t s1_q, s1_d;
  s2_t s2_q, s2_d;
  s3_t s3_q, s3_d;
  logic [VW-1:0] red_q, red_d;
  logic [VW-1:0] green_q, green_d;
  logic [VW-1:0] blue_q, blue_d;

  // ---------------------------------------------------------------------
  // flow control: a stage loads when it is empty or its successor moves
  // ---------------------------------------------------------------------
  always_comb begin
    stage_en[NSTAGES-1] = !vld_q[NSTAGES-1] || rgb_o.ready;
    for (int i = NSTAGES - 2; i >= 0; i--) begin
      stage_en[i] = !vld_q[i] || stage_en[i+1];
    end
  end

  assign hsv_i.ready = stage_en[0];

  always_comb begin
    vld_d = vld_q;
    if (stage_en[0]) begin
      vld_d[0] = hsv_i.valid;
    end
    for (int i = 1; i < NSTAGES; i++) begin
      if (stage_en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: clamp saturation and value, split hue*6 into sextant/fraction
  // ---------------------------------------------------------------------
  logic [HW-1:0] hue6;
  logic [VW-1:0] sat_clamped;
  logic [VW-1:0] val_clamped;

  always_comb begin
    sat_clamped = (hsv_i.saturation > ONE) ? ONE : hsv_i.saturation;
    val_clamped = (hsv_i.brightness > ONE) ? ONE : hsv_i.brightness;
    hue6        = HW'(hsv_i.hue) * HW'(SEXTANTS);

    s1_d.sext  = hue6[HW-1:FRAC_BITS];
    s1_d.frac  = hue6[FRAC_BITS-1:0];
    s1_d.sat   = sat_clamped;
    s1_d.val   = val_clamped;
    s1_d.black = (val_clamped == '0);
    s1_d.gray  = (sat_clamped == '0);
  end

  // ---------------------------------------------------------------------
  // stage 2: p = v*(1-s), kq = s*f, kt = s*(1-f), all truncated
  // ---------------------------------------------------------------------
  logic [PW-1:0] prod_p;
  logic [PW-1:0] prod_kq;
  logic [PW-1:0] prod_kt;

  always_comb begin
    prod_p  = PW'(s1_q.val) * PW'(ONE - s1_q.sat);
    prod_kq = PW'(s1_q.sat) * PW'(s1_q.frac);
    prod_kt = PW'(s1_q.sat) * PW'(ONE - VW'(s1_q.frac));

    s2_d.sext  = s1_q.sext;
    s2_d.val   = s1_q.val;
    s2_d.p     = prod_p[FRAC_BITS +: VW];
    s2_d.kq    = prod_kq[FRAC_BITS +: VW];
    s2_d.kt    = prod_kt[FRAC_BITS +: VW];
    s2_d.black = s1_q.black;
    s2_d.gray  = s1_q.gray;
  end

  // ---------------------------------------------------------------------
  // stage 3: q = v*(1-kq), t = v*(1-kt)
  // ---------------------------------------------------------------------
  logic [PW-1:0] prod_q;
  logic [PW-1:0] prod_t;

  always_comb begin
    prod_q = PW'(s2_q.val) * PW'(ONE - s2_q.kq);
    prod_t = PW'(s2_q.val) * PW'(ONE - s2_q.kt);

    s3_d.sext  = s2_q.sext;
    s3_d.val   = s2_q.val;
    s3_d.p     = s2_q.p;
    s3_d.q     = prod_q[FRAC_BITS +: VW];
    s3_d.t     = prod_t[FRAC_BITS +: VW];
    s3_d.black = s2_q.black;
    s3_d.gray  = s2_q.gray;
  end

  // ---------------------------------------------------------------------
  // output stage: route v, p, q, t by sextant, special cases override
  // ---------------------------------------------------------------------
  always_comb begin
    if (s3_q.black) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end else if (s3_q.gray) begin
      red_d   = s3_q.val;
      green_d = s3_q.val;
      blue_d  = s3_q.val;
    end else begin
      case (s3_q.sext)
        SEXT_RED_YEL: begin
          red_d   = s3_q.val;
          green_d = s3_q.t;
          blue_d  = s3_q.p;
        end
        SEXT_YEL_GRN: begin
          red_d   = s3_q.q;
          green_d = s3_q.val;
          blue_d  = s3_q.p;
        end
        SEXT_GRN_CYN: begin
          red_d   = s3_q.p;
          green_d = s3_q.val;
          blue_d  = s3_q.t;
        end
        SEXT_CYN_BLU: begin
          red_d   = s3_q.p;
          green_d = s3_q.q;
          blue_d  = s3_q.val;
        end
        SEXT_BLU_MAG: begin
          red_d   = s3_q.t;
          green_d = s3_q.p;
          blue_d  = s3_q.val;
        end
        SEXT_MAG_RED: begin
          red_d   = s3_q.val;
          green_d = s3_q.p;
          blue_d  = s3_q.q;
        end
        default: begin
          red_d   = s3_q.val;
          green_d = s3_q.t;
          blue_d  = s3_q.p;
        end
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s1_q <= s1_d;
    end
    if (stage_en[1]) begin
      s2_q <= s2_d;
    end
    if (stage_en[2]) begin
      s3_q <= s3_d;
    end
    if (stage_en[3]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign rgb_o.valid = vld_q[NSTAGES-1];
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

`ifndef SYNTHESIS
  // an accepted request always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_i.valid && hsv_i.ready |=> vld_q[0])
    else $error("accepted request did not enter stage 1");

  // input backpressure only when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_i.ready |-> (&vld_q))
    else $error("input stalled with an empty pipeline stage");

  // a blocked middle stage keeps its item intact
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !stage_en[2] |=> vld_q[1] && $stable(s2_q))
    else $error("stage 2 item lost or changed during stall");

  // results never exceed 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_o.valid |-> (red_q <= ONE) && (green_q <= ONE) && (blue_q <= ONE))
    else $error("color channel above full scale");
`endif

endmodule
